[rtl/rhfe_pkg.sv]
// shared types and constants for the radiotap header field extractor
package rhfe_pkg;

	localparam int INDEX_WIDTH_DEF = 16;

	localparam logic [15:0] HDR_MIN = 16'd8;
	localparam logic [15:0] EXT_WORD_BYTES = 16'd4;
	localparam logic [7:0] FLAGS_BAD_FCS = 8'h40;
	localparam logic [16:0] RATE_STEP_KBPS = 17'd500;
	localparam logic signed [7:0] SIGNAL_ABSENT = -8'sd100;

	localparam logic [15:0] FREQ_24_LO = 16'd2412;
	localparam logic [15:0] FREQ_24_HI = 16'd2472;
	localparam logic [15:0] FREQ_24_BASE = 16'd2407;
	localparam logic [15:0] FREQ_CH14 = 16'd2484;
	localparam logic [7:0] CHAN_14 = 8'd14;
	localparam logic [15:0] FREQ_5_LO = 16'd5160;
	localparam logic [15:0] FREQ_5_HI = 16'd5895;
	localparam logic [15:0] FREQ_5_BASE = 16'd5000;
	localparam logic [15:0] FREQ_6_LO = 16'd5955;
	localparam logic [15:0] FREQ_6_HI = 16'd7115;
	localparam logic [15:0] FREQ_6_BASE = 16'd5950;
	// ceil(2^16 / 5), exact quotient for offsets below 2048
	localparam logic [24:0] DIV5_RECIP = 25'd13108;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_t;

	typedef struct packed {
		logic              ok;
		logic [15:0]       hdr_length;
		logic              flags_present;
		logic              bad_fcs;
		logic [16:0]       data_rate;
		logic [15:0]       chan_freq;
		logic [7:0]        channel_number;
		logic              signal_present;
		logic signed [7:0] ant_signal;
	} out_t;

	typedef struct packed {
		logic        flags_en;
		logic        rate_en;
		logic        freq_en;
		logic        sig_en;
		logic [15:0] flags_pos;
		logic [15:0] rate_pos;
		logic [15:0] freq_pos;
		logic [15:0] sig_pos;
	} plan_t;

	typedef struct packed {
		logic [7:0] flags_byte;
		logic [7:0] rate_byte;
		logic [7:0] freq_lo;
		logic [7:0] freq_hi;
		logic [7:0] sig_byte;
	} cap_t;

	typedef struct packed {
		logic        len_ok;
		logic        err;
		logic [15:0] hlen;
		logic        flags_en;
		logic        rate_en;
		logic        freq_en;
		logic        sig_en;
		cap_t        cap;
	} snap_t;

endpackage

[rtl/radiotap_header_field_extractor_core.sv]
// top level of the radiotap header field extractor
// Takes a captured frame one byte per transfer, with the final byte marked, at one byte per
// cycle while the input is not stalled; the per-byte work is a compare-and-capture against
// positions planned when the present words end, so no byte ever waits on another. The result
// for a frame is registered into the output buffer when its last byte is taken. Results sit
// in a two-entry buffer, so input stalls only while two finished results wait unread. No
// clearing pass after reset. The byte count saturates at 2^INDEX_WIDTH - 1; bytes at or past
// that count are not captured.
module radiotap_header_field_extractor_core #(
	parameter int INDEX_WIDTH = rhfe_pkg::INDEX_WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  rhfe_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output rhfe_pkg::out_t out_data
);

	logic            accept;
	logic            fire;
	rhfe_pkg::snap_t snap;
	rhfe_pkg::out_t  res;
	logic            space;

	assign in_ready = space;
	assign accept = in_valid && in_ready;

	rhfe_parser #(
		.INDEX_WIDTH(INDEX_WIDTH)
	) u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.in_data(in_data),
		.fire(fire),
		.snap(snap)
	);

	rhfe_result u_result (
		.snap(snap),
		.res(res)
	);

	rhfe_out_buf u_out_buf (
		.clk(clk),
		.arst_n(arst_n),
		.push(fire),
		.push_data(res),
		.space(space),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

endmodule

[rtl/rhfe_parser.sv]
// per-byte header walk: length, present words, field placement and capture
module rhfe_parser #(
	parameter int INDEX_WIDTH = rhfe_pkg::INDEX_WIDTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  rhfe_pkg::in_t   in_data,
	output logic            fire,
	output rhfe_pkg::snap_t snap
);

	typedef enum logic [1:0] {PH_HEAD, PH_EXT, PH_FIELDS, PH_DONE} phase_t;

	localparam logic [INDEX_WIDTH-1:0] IDX_MAX = {INDEX_WIDTH{1'b1}};

	logic [INDEX_WIDTH-1:0] idx_q, idx_n;
	logic [15:0]            hlen_q, hlen_n;
	logic [5:0]             pw0_q, pw0_n;
	logic [15:0]            ws_q, ws_n;
	phase_t                 ph_q, ph_n;
	logic                   err_q, err_n;
	rhfe_pkg::plan_t        pl_q, pl_n;
	rhfe_pkg::cap_t         cap_q, cap_n;
	logic                   adv;
	logic                   adv_cont;
	logic [15:0]            adv_off;
	logic [7:0]             b;

	function automatic rhfe_pkg::plan_t plan_fields(logic [15:0] o_in, logic [5:0] p,
			logic [15:0] rt);
		rhfe_pkg::plan_t pl;
		logic [17:0]     o;
		logic [17:0]     r;
		logic            stop;
		pl = '0;
		o = {2'b00, o_in};
		r = {2'b00, rt};
		stop = 1'b0;
		if (p[0]) begin
			o = ((o + 18'd7) & ~18'd7) + 18'd8;
		end
		if (p[1]) begin
			if (o + 18'd1 > r) begin
				stop = 1'b1;
			end else begin
				pl.flags_en = 1'b1;
				pl.flags_pos = o[15:0];
				o = o + 18'd1;
			end
		end
		if (p[2] && !stop) begin
			if (o + 18'd1 > r) begin
				stop = 1'b1;
			end else begin
				pl.rate_en = 1'b1;
				pl.rate_pos = o[15:0];
				o = o + 18'd1;
			end
		end
		if (p[3] && !stop) begin
			o = (o + 18'd1) & ~18'd1;
			if (o + 18'd2 <= r) begin
				pl.freq_en = 1'b1;
				pl.freq_pos = o[15:0];
			end
			o = o + 18'd4;
		end
		if (p[4] && !stop) begin
			o = o + 18'd2;
		end
		if (p[5] && !stop) begin
			if (o < r) begin
				pl.sig_en = 1'b1;
				pl.sig_pos = o[15:0];
			end
		end
		return pl;
	endfunction

	assign b = in_data.data_byte;

	always_comb begin
		idx_n = idx_q;
		hlen_n = hlen_q;
		pw0_n = pw0_q;
		ws_n = ws_q;
		ph_n = ph_q;
		err_n = err_q;
		pl_n = pl_q;
		cap_n = cap_q;
		adv = 1'b0;
		adv_cont = 1'b0;
		adv_off = '0;
		if (idx_q != IDX_MAX) begin
			idx_n = idx_q + 1'b1;
			if ((idx_q >> 3) == '0) begin
				unique case (idx_q[2:0])
					3'd2: hlen_n[7:0] = b;
					3'd3: hlen_n[15:8] = b;
					3'd4: pw0_n = b[5:0];
					3'd7: begin
						adv = 1'b1;
						adv_cont = b[7];
						adv_off = rhfe_pkg::HDR_MIN;
					end
					default: ;
				endcase
			end else if (ph_q == PH_EXT) begin
				if (idx_q[1:0] == 2'b11) begin
					adv = 1'b1;
					adv_cont = b[7];
					adv_off = ws_q + rhfe_pkg::EXT_WORD_BYTES;
				end
			end else if (ph_q == PH_FIELDS) begin
				if (pl_q.flags_en && 32'(idx_q) == 32'(pl_q.flags_pos)) cap_n.flags_byte = b;
				if (pl_q.rate_en && 32'(idx_q) == 32'(pl_q.rate_pos)) cap_n.rate_byte = b;
				if (pl_q.freq_en && 32'(idx_q) == 32'(pl_q.freq_pos)) cap_n.freq_lo = b;
				if (pl_q.freq_en && 32'(idx_q) == 32'(pl_q.freq_pos) + 32'd1) begin
					cap_n.freq_hi = b;
				end
				if (pl_q.sig_en && 32'(idx_q) == 32'(pl_q.sig_pos)) cap_n.sig_byte = b;
			end
		end
		if (adv) begin
			if (adv_cont) begin
				if (17'(adv_off) + 17'(rhfe_pkg::EXT_WORD_BYTES) > 17'(hlen_q)) begin
					err_n = 1'b1;
					ph_n = PH_DONE;
				end else begin
					ws_n = adv_off;
					ph_n = PH_EXT;
				end
			end else begin
				pl_n = plan_fields(adv_off, pw0_n, hlen_q);
				ph_n = PH_FIELDS;
			end
		end
	end

	assign fire = accept && in_data.last_byte;

	always_comb begin
		snap.len_ok = (32'(idx_n) >= 32'(rhfe_pkg::HDR_MIN)) && (hlen_n >= rhfe_pkg::HDR_MIN)
			&& (32'(hlen_n) <= 32'(idx_n));
		snap.err = err_n;
		snap.hlen = hlen_n;
		snap.flags_en = pl_n.flags_en;
		snap.rate_en = pl_n.rate_en;
		snap.freq_en = pl_n.freq_en;
		snap.sig_en = pl_n.sig_en;
		snap.cap = cap_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			hlen_q <= '0;
			pw0_q <= '0;
			ws_q <= '0;
			ph_q <= PH_HEAD;
			err_q <= 1'b0;
			pl_q <= '0;
			cap_q <= '0;
		end else if (accept) begin
			pw0_q <= pw0_n;
			ws_q <= ws_n;
			cap_q <= cap_n;
			if (in_data.last_byte) begin
				idx_q <= '0;
				hlen_q <= '0;
				ph_q <= PH_HEAD;
				err_q <= 1'b0;
				pl_q <= '0;
			end else begin
				idx_q <= idx_n;
				hlen_q <= hlen_n;
				ph_q <= ph_n;
				err_q <= err_n;
				pl_q <= pl_n;
			end
		end
	end

endmodule

[rtl/rhfe_result.sv]
// result formatting: rate scaling, channel number, absent values
module rhfe_result (
	input  rhfe_pkg::snap_t snap,
	output rhfe_pkg::out_t  res
);

	logic [15:0] f;
	logic [15:0] base;
	logic [10:0] ofs;
	logic [24:0] prod;
	logic [7:0]  chan;
	logic        in_24;
	logic        in_5;
	logic        in_6;

	assign f = {snap.cap.freq_hi, snap.cap.freq_lo};
	assign in_24 = (f >= rhfe_pkg::FREQ_24_LO) && (f <= rhfe_pkg::FREQ_24_HI);
	assign in_5 = (f >= rhfe_pkg::FREQ_5_LO) && (f <= rhfe_pkg::FREQ_5_HI);
	assign in_6 = (f >= rhfe_pkg::FREQ_6_LO) && (f <= rhfe_pkg::FREQ_6_HI);

	always_comb begin
		priority if (in_24) base = rhfe_pkg::FREQ_24_BASE;
		else if (in_5) base = rhfe_pkg::FREQ_5_BASE;
		else base = rhfe_pkg::FREQ_6_BASE;
	end

	// divide by five through the reciprocal
	assign ofs = 11'(f - base);
	assign prod = 25'(ofs) * rhfe_pkg::DIV5_RECIP;

	always_comb begin
		priority if (in_24 || in_5 || in_6) chan = prod[23:16];
		else if (f == rhfe_pkg::FREQ_CH14) chan = rhfe_pkg::CHAN_14;
		else chan = '0;
	end

	always_comb begin
		res = '0;
		res.ant_signal = rhfe_pkg::SIGNAL_ABSENT;
		if (snap.len_ok) begin
			res.hdr_length = snap.hlen;
			if (!snap.err) begin
				res.ok = 1'b1;
				if (snap.flags_en) begin
					res.flags_present = 1'b1;
					res.bad_fcs = |(snap.cap.flags_byte & rhfe_pkg::FLAGS_BAD_FCS);
				end
				if (snap.rate_en) begin
					res.data_rate = 17'(snap.cap.rate_byte) * rhfe_pkg::RATE_STEP_KBPS;
				end
				if (snap.freq_en) begin
					res.chan_freq = f;
					res.channel_number = chan;
				end
				if (snap.sig_en) begin
					res.signal_present = 1'b1;
					res.ant_signal = snap.cap.sig_byte;
				end
			end
		end
	end

endmodule

[rtl/rhfe_out_buf.sv]
// two-entry result register with skid slot
module rhfe_out_buf (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rhfe_pkg::out_t push_data,
	output logic           space,
	output logic           out_valid,
	input  logic           out_ready,
	output rhfe_pkg::out_t out_data
);

	logic           main_v_q;
	logic           skid_v_q;
	rhfe_pkg::out_t main_q;
	rhfe_pkg::out_t skid_q;
	logic           pop;

	assign pop = main_v_q && out_ready;
	assign space = !skid_v_q;
	assign out_valid = main_v_q;
	assign out_data = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (pop && push) begin
				main_v_q <= 1'b1;
			end else if (pop) begin
				if (skid_v_q) begin
					skid_v_q <= 1'b0;
				end else begin
					main_v_q <= 1'b0;
				end
			end else if (push) begin
				if (main_v_q) begin
					skid_v_q <= 1'b1;
				end else begin
					main_v_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && push) begin
			main_q <= push_data;
		end else if (pop) begin
			if (skid_v_q) main_q <= skid_q;
		end else if (push) begin
			if (main_v_q) begin
				skid_q <= push_data;
			end else begin
				main_q <= push_data;
			end
		end
	end

endmodule

[verif/radiotap_header_field_extractor_core_tb.sv]
// self-checking testbench for the radiotap header field extractor core
`timescale 1ns / 1ps

class frame_scoreboard;

	typedef enum logic [1:0] {P_HEAD, P_EXT, P_FIELDS, P_DONE} parse_phase_e;

	localparam int unsigned IDX_MAX = (1 << rhfe_pkg::INDEX_WIDTH_DEF) - 1;

	int unsigned byte_cnt;
	bit [15:0] hdr_len;
	bit [31:0] present_first;
	bit [31:0] present_cur;
	bit in_ext;
	int unsigned next_off;
	int unsigned word_base;
	parse_phase_e phase;
	bit flags_en, rate_en, freq_en, sig_en;
	int unsigned flags_pos, rate_pos, freq_pos, sig_pos;
	bit [7:0] flags_b, rate_b, freq_lo, freq_hi, sig_b;
	bit trunc_err;

	rhfe_pkg::out_t expected_q[$];
	int errors;
	int results_seen;

	function new();
		errors = 0;
		results_seen = 0;
		clear_state();
	endfunction

	function void clear_state();
		byte_cnt = 0;
		hdr_len = '0;
		present_first = '0;
		present_cur = '0;
		in_ext = 1'b0;
		next_off = 0;
		word_base = 0;
		phase = P_HEAD;
		flags_en = 1'b0;
		rate_en = 1'b0;
		freq_en = 1'b0;
		sig_en = 1'b0;
		flags_pos = 0;
		rate_pos = 0;
		freq_pos = 0;
		sig_pos = 0;
		flags_b = '0;
		rate_b = '0;
		freq_lo = '0;
		freq_hi = '0;
		sig_b = 8'h9C;
		trunc_err = 1'b0;
	endfunction

	function bit [7:0] chan_of_freq(bit [15:0] f);
		int unsigned fi;
		fi = f;
		if (fi >= 2412 && fi <= 2472) return 8'((fi - 2407) / 5);
		if (fi == 2484) return 8'd14;
		if (fi >= 5160 && fi <= 5895) return 8'((fi - 5000) / 5);
		if (fi >= 5955 && fi <= 7115) return 8'((fi - 5950) / 5);
		return 8'd0;
	endfunction

	function void place_fields(int unsigned o);
		int unsigned lim;
		lim = hdr_len;
		if (present_first[0]) o = ((o + 7) & ~32'd7) + 8;
		if (present_first[1]) begin
			if (o + 1 > lim) return;
			flags_en = 1'b1;
			flags_pos = o;
			o = o + 1;
		end
		if (present_first[2]) begin
			if (o + 1 > lim) return;
			rate_en = 1'b1;
			rate_pos = o;
			o = o + 1;
		end
		if (present_first[3]) begin
			o = (o + 1) & ~32'd1;
			if (o + 2 <= lim) begin
				freq_en = 1'b1;
				freq_pos = o;
			end
			o = o + 4;
		end
		if (present_first[4]) o = o + 2;
		if (present_first[5]) begin
			if (o < lim) begin
				sig_en = 1'b1;
				sig_pos = o;
			end
		end
	endfunction

	function void walk_chain();
		if (present_cur[31]) begin
			if (next_off + 4 > hdr_len) begin
				trunc_err = 1'b1;
				in_ext = 1'b0;
				phase = P_DONE;
			end else begin
				word_base = next_off;
				present_cur = '0;
				in_ext = 1'b1;
				phase = P_EXT;
			end
		end else begin
			in_ext = 1'b0;
			place_fields(next_off);
			phase = P_FIELDS;
		end
	endfunction

	function rhfe_pkg::out_t frame_result();
		rhfe_pkg::out_t r;
		r = '0;
		r.ant_signal = -8'sd100;
		if (byte_cnt >= 8 && hdr_len >= 8 && hdr_len <= byte_cnt) begin
			r.hdr_length = hdr_len;
			if (!trunc_err) begin
				r.ok = 1'b1;
				if (flags_en) begin
					r.flags_present = 1'b1;
					r.bad_fcs = flags_b[6];
				end
				if (rate_en) r.data_rate = {9'd0, rate_b} * 17'd500;
				if (freq_en) begin
					r.chan_freq = {freq_hi, freq_lo};
					r.channel_number = chan_of_freq({freq_hi, freq_lo});
				end
				if (sig_en) begin
					r.signal_present = 1'b1;
					r.ant_signal = sig_b;
				end
			end
		end
		return r;
	endfunction

	function void note_byte(rhfe_pkg::in_t item);
		bit [7:0] b;
		int unsigned pos;
		int unsigned k;
		b = item.data_byte;
		if (byte_cnt < IDX_MAX) begin
			pos = byte_cnt;
			if (pos < 8) begin
				if (pos == 2) hdr_len[7:0] = b;
				if (pos == 3) hdr_len[15:8] = b;
				if (pos >= 4) begin
					present_first = present_first | ({24'd0, b} << (8 * (pos - 4)));
					if (pos == 7) begin
						present_cur = present_first;
						next_off = 8;
						walk_chain();
					end
				end
			end else if (phase == P_EXT) begin
				k = (pos - word_base) & 3;
				present_cur = present_cur | ({24'd0, b} << (8 * k));
				if (k == 3) begin
					next_off = word_base + 4;
					walk_chain();
				end
			end else if (phase == P_FIELDS) begin
				if (flags_en && pos == flags_pos) flags_b = b;
				if (rate_en && pos == rate_pos) rate_b = b;
				if (freq_en && pos == freq_pos) freq_lo = b;
				if (freq_en && pos == freq_pos + 1) freq_hi = b;
				if (sig_en && pos == sig_pos) sig_b = b;
			end
			byte_cnt = pos + 1;
		end else begin
			byte_cnt = IDX_MAX;
		end
		if (item.last_byte) begin
			expected_q.push_back(frame_result());
			clear_state();
		end
	endfunction

	task report_mismatch(string msg);
		$display("result %0d: %s", results_seen, msg);
		errors++;
	endtask

	task check_result(rhfe_pkg::out_t got);
		rhfe_pkg::out_t exp;
		results_seen++;
		if (expected_q.size() == 0) begin
			report_mismatch("unexpected result transfer");
			return;
		end
		exp = expected_q.pop_front();
		if (got.ok !== exp.ok)
			report_mismatch($sformatf("ok got %0d exp %0d", got.ok, exp.ok));
		if (got.hdr_length !== exp.hdr_length)
			report_mismatch($sformatf("hdr_length got %0d exp %0d",
				got.hdr_length, exp.hdr_length));
		if (got.flags_present !== exp.flags_present)
			report_mismatch($sformatf("flags_present got %0d exp %0d",
				got.flags_present, exp.flags_present));
		if (got.bad_fcs !== exp.bad_fcs)
			report_mismatch($sformatf("bad_fcs got %0d exp %0d", got.bad_fcs, exp.bad_fcs));
		if (got.data_rate !== exp.data_rate)
			report_mismatch($sformatf("data_rate got %0d exp %0d",
				got.data_rate, exp.data_rate));
		if (got.chan_freq !== exp.chan_freq)
			report_mismatch($sformatf("chan_freq got %0d exp %0d",
				got.chan_freq, exp.chan_freq));
		if (got.channel_number !== exp.channel_number)
			report_mismatch($sformatf("channel_number got %0d exp %0d",
				got.channel_number, exp.channel_number));
		if (got.signal_present !== exp.signal_present)
			report_mismatch($sformatf("signal_present got %0d exp %0d",
				got.signal_present, exp.signal_present));
		if (got.ant_signal !== exp.ant_signal)
			report_mismatch($sformatf("ant_signal got %0d exp %0d",
				got.ant_signal, exp.ant_signal));
	endtask

	function int pending();
		return expected_q.size();
	endfunction

endclass

module radiotap_header_field_extractor_core_tb;

	typedef enum int {
		FR_GOOD, FR_TRUNC_FIELD, FR_TRUNC_EXT, FR_BAD_LEN, FR_SHORT, FR_NOISE
	} frame_kind_e;

	localparam int CYCLE_LIMIT = 500000;
	localparam int RANDOM_BYTES_PER_PHASE = 610;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	rhfe_pkg::in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	rhfe_pkg::out_t out_data;

	int src_idle_pct = 0;
	int sink_idle_pct = 0;
	int cycle_count = 0;
	int bytes_sent = 0;
	bit [7:0] frame_q[$];

	frame_scoreboard sb = new();

	radiotap_header_field_extractor_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		forever begin
			@(negedge clk);
			out_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_result(out_data);
	end

	function automatic bit [15:0] pick_freq();
		case ($urandom_range(0, 19))
			0: return 16'd2411;
			1: return 16'd2412;
			2: return 16'd2437;
			3: return 16'd2472;
			4: return 16'd2473;
			5: return 16'd2484;
			6: return 16'd5159;
			7: return 16'd5160;
			8: return 16'd5183;
			9: return 16'd5895;
			10: return 16'd5896;
			11: return 16'd5954;
			12: return 16'd5955;
			13: return 16'd6417;
			14: return 16'd7115;
			15: return 16'd7116;
			16: return 16'd0;
			17: return 16'hFFFF;
			18: return 16'($urandom_range(2400, 7200));
			default: return 16'($urandom());
		endcase
	endfunction

	task automatic build_frame(frame_kind_e kind);
		bit [31:0] present;
		bit [31:0] ext_w;
		bit [15:0] f;
		int unsigned n_ext;
		int unsigned ext_end;
		int unsigned o;
		int unsigned hl;
		int unsigned total;
		int unsigned keep;
		frame_q.delete();
		if (kind == FR_NOISE) begin
			repeat ($urandom_range(1, 24)) frame_q.push_back(8'($urandom()));
			return;
		end
		present = $urandom();
		if ($urandom_range(0, 3) != 0) present[30:6] = '0;
		if (kind == FR_TRUNC_EXT) n_ext = $urandom_range(1, 3);
		else n_ext = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
		present[31] = (n_ext != 0);
		frame_q.push_back(8'($urandom()));
		frame_q.push_back(8'($urandom()));
		frame_q.push_back(8'h00);
		frame_q.push_back(8'h00);
		for (int i = 0; i < 4; i++) frame_q.push_back(present[8*i +: 8]);
		for (int unsigned w = 0; w < n_ext; w++) begin
			ext_w = $urandom();
			ext_w[31] = (w != n_ext - 1);
			for (int i = 0; i < 4; i++) frame_q.push_back(ext_w[8*i +: 8]);
		end
		ext_end = frame_q.size();
		if (present[0]) begin
			o = ((ext_end + 7) & ~32'd7) + 8;
			while (frame_q.size() < o) frame_q.push_back(8'($urandom()));
		end
		if (present[1]) frame_q.push_back(8'($urandom()));
		if (present[2]) frame_q.push_back(8'($urandom()));
		if (present[3]) begin
			if (frame_q.size() % 2 != 0) frame_q.push_back(8'($urandom()));
			f = pick_freq();
			frame_q.push_back(f[7:0]);
			frame_q.push_back(f[15:8]);
			frame_q.push_back(8'($urandom()));
			frame_q.push_back(8'($urandom()));
		end
		if (present[4]) begin
			frame_q.push_back(8'($urandom()));
			frame_q.push_back(8'($urandom()));
		end
		if (present[5]) frame_q.push_back(8'($urandom()));
		o = frame_q.size();
		case (kind)
			FR_TRUNC_FIELD: hl = (o >= 8 + 6) ? o - $urandom_range(1, 6) : 8;
			FR_TRUNC_EXT: hl = $urandom_range(8, ext_end - 1);
			default: hl = o + $urandom_range(0, 3);
		endcase
		while (frame_q.size() < hl) frame_q.push_back(8'($urandom()));
		repeat ($urandom_range(0, 12)) frame_q.push_back(8'($urandom()));
		total = frame_q.size();
		if (kind == FR_BAD_LEN) begin
			case ($urandom_range(0, 2))
				0: hl = $urandom_range(0, 7);
				1: hl = total + $urandom_range(1, 40);
				default: hl = $urandom_range(total + 1, 65535);
			endcase
		end
		frame_q[2] = hl[7:0];
		frame_q[3] = hl[15:8];
		if (kind == FR_SHORT) begin
			keep = $urandom_range(1, 7);
			while (frame_q.size() > keep) void'(frame_q.pop_back());
		end
	endtask

	task automatic send_byte(rhfe_pkg::in_t item);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_byte(item);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_frame();
		rhfe_pkg::in_t item;
		foreach (frame_q[i]) begin
			item.data_byte = frame_q[i];
			item.last_byte = (i == frame_q.size() - 1);
			send_byte(item);
		end
	endtask

	task automatic random_frames(int target);
		int unsigned pick;
		frame_kind_e kind;
		bytes_sent = 0;
		while (bytes_sent < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) kind = FR_GOOD;
			else if (pick < 70) kind = FR_TRUNC_FIELD;
			else if (pick < 78) kind = FR_TRUNC_EXT;
			else if (pick < 86) kind = FR_BAD_LEN;
			else if (pick < 93) kind = FR_SHORT;
			else kind = FR_NOISE;
			build_frame(kind);
			send_frame();
		end
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		src_idle_pct = 10;
		sink_idle_pct = 78;
		// one-byte and seven-byte buffers, minimal header, flags and signal extremes
		frame_q = '{8'hA5};
		send_frame();
		frame_q = '{8'h00, 8'h00, 8'h08, 8'h00, 8'h22, 8'h00, 8'h00};
		send_frame();
		frame_q = '{8'h00, 8'h00, 8'h08, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
		send_frame();
		frame_q = '{8'h00, 8'h00, 8'h0A, 8'h00, 8'h22, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h80};
		send_frame();

		random_frames(RANDOM_BYTES_PER_PHASE);

		src_idle_pct = 78;
		sink_idle_pct = 10;
		random_frames(RANDOM_BYTES_PER_PHASE);

		src_idle_pct = 0;
		sink_idle_pct = 0;
		random_frames(RANDOM_BYTES_PER_PHASE);

		in_valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
